// File: rtl/stt_pkg.sv
// Shared types, character codes and class decode for the spec text tokenizer.
// No dependencies; used by every module of the block.
package stt_pkg;

   // token kinds carried on the result channel
   typedef enum logic [2:0] {
      KIND_PUNCT  = 3'd0,
      KIND_WORD   = 3'd1,
      KIND_STRING = 3'd2,
      KIND_UNTERM = 3'd3,
      KIND_BAD    = 3'd4,
      KIND_END    = 3'd5
   } stt_kind_type;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // most result items one input beat can produce, and result queue depth
   localparam int MaxResults = 3;
   localparam int QueueDepth = 4;

   // one result item
   typedef struct packed {
      logic [7:0]   token_byte;
      stt_kind_type token_kind;
      logic         token_first;
      logic         token_last;
      logic         no_character;
   } stt_item_type;

   // results from one input beat, item 0 goes out first
   typedef struct packed {
      logic [1:0]                    cnt;
      stt_item_type [MaxResults-1:0] item;
   } stt_group_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_word(input logic [7:0] c, input logic colon_mode);
      logic alnum;
      alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
              (c >= 8'h61 && c <= 8'h7A);
      return alnum || c == CH_UNDER || c == CH_STAR || c == CH_LBRACK ||
             c == CH_RBRACK || c == CH_QMARK || c == CH_DOT ||
             (colon_mode && c == CH_COLON);
   endfunction

   function automatic stt_item_type make_item(input logic [7:0] ch, input stt_kind_type kind,
                                              input logic first, input logic last,
                                              input logic nochar);
      stt_item_type it;
      it.token_byte   = nochar ? 8'h00 : ch;
      it.token_kind   = kind;
      it.token_first  = first;
      it.token_last   = last;
      it.no_character = nochar;
      return it;
   endfunction

endpackage

// File: rtl/stt_scan.sv
// Scanner state and token decode: one held lookahead byte plus comment,
// string and word flags. Depends on stt_pkg.
module stt_scan
   import stt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    text_byte,
   input  logic          colon_in_words,
   input  logic          end_of_input,
   output stt_group_type group
);

   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       held_mode_ff, held_mode_in;
   logic       block_cmt_ff, block_cmt_in;
   logic       line_cmt_ff, line_cmt_in;
   logic       in_str_ff, in_str_in;
   logic       str_text_ff, str_text_in;
   logic       in_word_ff, in_word_in;
   logic       drop_ff, drop_in;
   logic       ended_ff, ended_in;

   // decode of the held byte against the incoming one
   always_comb begin
      logic         p_vld;
      logic         nvalid;
      logic         last;
      logic [7:0]   h;
      stt_item_type p_item;
      stt_item_type u_item;
      stt_item_type e_item;

      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      held_mode_in  = held_mode_ff;
      block_cmt_in  = block_cmt_ff;
      line_cmt_in   = line_cmt_ff;
      in_str_in     = in_str_ff;
      str_text_in   = str_text_ff;
      in_word_in    = in_word_ff;
      drop_in       = drop_ff;
      ended_in      = ended_ff;
      group         = '0;
      p_vld         = 1'b0;
      p_item        = '0;
      u_item        = '0;
      e_item        = '0;
      last          = 1'b0;
      h             = held_byte_ff;
      nvalid        = !end_of_input;

      if (accept && !ended_ff) begin
         if (held_valid_ff && drop_ff) begin
            drop_in = 1'b0;
         end else if (held_valid_ff) begin
            if (line_cmt_ff) begin
               if (h == CH_LF) line_cmt_in = 1'b0;
            end else if (in_str_ff) begin
               if (h == CH_QUOTE) begin
                  p_vld     = 1'b1;
                  p_item    = make_item(8'h00, KIND_STRING, !str_text_ff, 1'b1, 1'b1);
                  in_str_in = 1'b0;
               end else if (h == CH_LF || h == CH_NUL) begin
                  p_vld     = 1'b1;
                  p_item    = make_item(8'h00, KIND_UNTERM, !str_text_ff, 1'b1, 1'b1);
                  in_str_in = 1'b0;
                  if (h == CH_NUL) line_cmt_in = 1'b1;
               end else begin
                  p_vld       = 1'b1;
                  p_item      = make_item(h, KIND_STRING, !str_text_ff, 1'b0, 1'b0);
                  str_text_in = 1'b1;
               end
            end else if (is_space(h)) begin
               // whitespace is dropped
            end else if (block_cmt_ff) begin
               if (h == CH_STAR && nvalid && text_byte == CH_SLASH) begin
                  block_cmt_in = 1'b0;
                  drop_in      = 1'b1;
               end else if (h == CH_NUL) begin
                  line_cmt_in = 1'b1;
               end
            end else if (h == CH_NUL) begin
               line_cmt_in = 1'b1;
            end else if (h == CH_SLASH && nvalid && text_byte == CH_STAR) begin
               block_cmt_in = 1'b1;
               drop_in      = 1'b1;
            end else if (h == CH_HASH || (h == CH_SLASH && nvalid && text_byte == CH_SLASH)) begin
               line_cmt_in = 1'b1;
            end else if (h == CH_LBRACE || h == CH_RBRACE || h == CH_SEMI ||
                         (h == CH_COLON && !held_mode_ff)) begin
               p_vld  = 1'b1;
               p_item = make_item(h, KIND_PUNCT, 1'b1, 1'b1, 1'b0);
            end else if (is_word(h, held_mode_ff)) begin
               last       = !(nvalid && is_word(text_byte, colon_in_words));
               p_vld      = 1'b1;
               p_item     = make_item(h, KIND_WORD, !in_word_ff, last, 1'b0);
               in_word_in = !last;
            end else if (h == CH_QUOTE) begin
               in_str_in   = 1'b1;
               str_text_in = 1'b0;
            end else begin
               p_vld  = 1'b1;
               p_item = make_item(h, KIND_BAD, 1'b1, 1'b1, 1'b0);
            end
         end

         if (!end_of_input) begin
            // shift the new byte into the lookahead slot
            held_byte_in  = text_byte;
            held_mode_in  = colon_in_words;
            held_valid_in = 1'b1;
            group.cnt     = {1'b0, p_vld};
            group.item[0] = p_item;
         end else begin
            // flush: held byte, open string marker, end marker
            u_item = make_item(8'h00, KIND_UNTERM, !str_text_in, 1'b1, 1'b1);
            e_item = make_item(8'h00, KIND_END, 1'b1, 1'b1, 1'b1);
            if (p_vld) begin
               group.item[0] = p_item;
               if (in_str_in) begin
                  group.item[1] = u_item;
                  group.item[2] = e_item;
                  group.cnt     = 2'd3;
               end else begin
                  group.item[1] = e_item;
                  group.cnt     = 2'd2;
               end
            end else if (in_str_in) begin
               group.item[0] = u_item;
               group.item[1] = e_item;
               group.cnt     = 2'd2;
            end else begin
               group.item[0] = e_item;
               group.cnt     = 2'd1;
            end
            held_byte_in  = 8'h00;
            held_valid_in = 1'b0;
            held_mode_in  = 1'b0;
            block_cmt_in  = 1'b0;
            line_cmt_in   = 1'b0;
            in_str_in     = 1'b0;
            str_text_in   = 1'b0;
            in_word_in    = 1'b0;
            drop_in       = 1'b0;
            ended_in      = 1'b1;
         end
      end
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         held_mode_ff  <= 1'b0;
         block_cmt_ff  <= 1'b0;
         line_cmt_ff   <= 1'b0;
         in_str_ff     <= 1'b0;
         str_text_ff   <= 1'b0;
         in_word_ff    <= 1'b0;
         drop_ff       <= 1'b0;
         ended_ff      <= 1'b0;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         held_mode_ff  <= held_mode_in;
         block_cmt_ff  <= block_cmt_in;
         line_cmt_ff   <= line_cmt_in;
         in_str_ff     <= in_str_in;
         str_text_ff   <= str_text_in;
         in_word_ff    <= in_word_in;
         drop_ff       <= drop_in;
         ended_ff      <= ended_in;
      end
   end

endmodule

// File: rtl/stt_queue.sv
// Result queue: takes up to three items per input beat, sends one per beat.
// Depends on stt_pkg.
module stt_queue
   import stt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stt_group_type group,
   output logic          room,
   output logic          out_valid,
   input  logic          out_ready,
   output stt_item_type  out_item
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   stt_item_type            q_ff [QueueDepth];
   stt_item_type            q_in [QueueDepth];
   logic [PtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]         count_ff, count_in;
   logic                    pop;

   // room for a full group of results
   assign room      = count_ff <= CntW'(QueueDepth - MaxResults);
   assign out_valid = count_ff != '0;
   assign out_item  = q_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // write up to three entries from the write pointer on
   always_comb begin
      for (int i = 0; i < QueueDepth; i++) begin
         q_in[i] = q_ff[i];
         for (int j = 0; j < MaxResults; j++) begin
            if (2'(j) < group.cnt && PtrW'(wr_ptr_ff + PtrW'(j)) == PtrW'(i))
               q_in[i] = group.item[j];
         end
      end
      wr_ptr_in = wr_ptr_ff + PtrW'(group.cnt);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + CntW'(group.cnt) - CntW'(pop);
   end

   // entries hold payload only
   always_ff @(posedge clock) begin
      for (int i = 0; i < QueueDepth; i++) q_ff[i] <= q_in[i];
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/spec_text_tokenizer.sv
// Specification text tokenizer top level: stream ports, scanner and result queue.
// Depends on stt_pkg, stt_scan and stt_queue.
//
// One text byte per beat goes in, one token character or marker per beat comes
// out, and back to back beats run at one byte per cycle on each side while
// rsp_tready stays high. Each byte is held as lookahead, so its token item is
// produced when the following byte is taken; the item is then registered into
// a four-entry result queue. A beat with req_tlast (end of input) flushes the
// held byte and may push up to three items (held character, unterminated-string
// marker, end marker); the input is not ready while more than one item waits in
// the queue, so that beat can stall the input until the queue drains to one
// item. After the end marker the block ignores further input until reset.
module spec_text_tokenizer
   import stt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] colon_in_words
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] token_byte, [8] token_first, [15:9] zero
   output logic [3:0]  rsp_tuser,   // [2:0] token_kind, [3] no_character
   output logic        rsp_tlast    // token_last
);

   stt_group_type group;
   stt_item_type  item;
   logic          room;
   logic          accept;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   stt_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .text_byte      (req_tdata),
      .colon_in_words (req_tuser),
      .end_of_input   (req_tlast),
      .group          (group)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .group     (group),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (item)
   );

   // pack the result beat
   assign rsp_tdata = {7'b0, item.token_first, item.token_byte};
   assign rsp_tuser = {item.no_character, item.token_kind};
   assign rsp_tlast = item.token_last;

endmodule

// File: rtl/stt_checker.sv
// Port-level checks on the tokenizer's result channel, bound to the top level.
// Depends on stt_pkg.
module stt_checker
   import stt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled beat keeps its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // the end marker is a complete, characterless token
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == KIND_END |->
      rsp_tlast && rsp_tuser[3] && rsp_tdata[8])
      else $error("malformed end marker");

   // marker items carry a zero byte and close their token
   a_marker_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tdata[7:0] == 8'h00 && rsp_tlast)
      else $error("marker item with character or open token");

   // punctuation and unexpected bytes are single-item tokens
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == KIND_PUNCT || rsp_tuser[2:0] == KIND_BAD) |->
      rsp_tdata[8] && rsp_tlast && !rsp_tuser[3])
      else $error("single-character token not first and last");

endmodule

bind spec_text_tokenizer stt_checker u_stt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
